/* src/mucn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Package for the mesh unit-cube normalizer.
// Shared widths, action and status codes, and the point store word.
// ----------------------------------------------------------------------------
package mucn_pkg;

  localparam int MAX_POINTS     = 4096;
  localparam int ADDR_W         = $clog2(MAX_POINTS);
  localparam int CNT_W          = $clog2(MAX_POINTS + 1);
  localparam int COORD_W        = 32;
  localparam int EXT_W          = COORD_W + 1;
  localparam int SUM_W          = COORD_W + ADDR_W;
  localparam int NUM_W          = CNT_W + EXT_W;
  localparam int OUT_W          = 18;
  localparam int OUT_FRAC       = 16;
  localparam int Q_W            = OUT_FRAC + 3;
  localparam int STEPS          = OUT_FRAC + 2;
  localparam int STEP_W         = $clog2(STEPS + 1);
  localparam int DEF_COORD_FRAC = 16;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_MEAN  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage

/* src/mucn_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point store.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mucn_store
  import mucn_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  point_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output point_t            rd_data
);

  point_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/mucn_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider.
// Returns round(num * 2^17 / den) - 2^16 with num clamped to den, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mucn_div
  import mucn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NUM_W-1:0]        num,
  input  logic [NUM_W-1:0]        den,
  output logic                    done,
  output logic signed [OUT_W-1:0] quot
);

  logic              busy;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  den_q;
  logic [Q_W-1:0]    q;
  logic [STEP_W-1:0] step;
  logic [NUM_W:0]    rem_sh;
  logic              take;
  logic [NUM_W:0]    rem_sub;
  logic [Q_W:0]      q_round;

  assign rem_sh  = {rem, 1'b0};
  assign take    = (rem_sh >= {1'b0, den_q}) && (den_q != '0);
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_round = ({1'b0, q} + (Q_W + 1)'(1)) >> 1;
  assign quot    = OUT_W'(q_round - ((Q_W + 1)'(1) << OUT_FRAC));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        den_q <= den;
        rem   <= '0;
        if (den == '0) begin
          q <= '0;
        end else if (num >= den) begin
          q <= Q_W'(1);
        end else begin
          q   <= '0;
          rem <= num;
        end
      end else if (busy) begin
        rem  <= take ? rem_sub[NUM_W-1:0] : rem_sh[NUM_W-1:0];
        q    <= {q[Q_W-2:0], take};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/mesh_unit_cube_normalizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh unit-cube normalizer.
// Stores points, tracks the bounding box and sums, and returns points or
// their mean mapped into the [-1,1] cube in Q1.16.
//
//   channel  valid         stall         payload
//   item     item_valid    item_stall    action coord_x coord_y coord_z
//                                        point_index
//   result   result_valid  result_stall  out_x out_y out_z status
//                                        point_count
//
// Load, clear and rejected requests go from idle straight to the final state.
// A point read or a mean uses the single divider, which produces one
// quotient bit per cycle for each of three axes in turn.
// Reset clears the count, box and sums; the point store is not cleared.
// A new word is taken while an earlier result waits; a stalled result
// holds the next one in its final state.
// ----------------------------------------------------------------------------
module mesh_unit_cube_normalizer
  import mucn_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [1:0]                action,
  input  logic signed [COORD_W-1:0] coord_x,
  input  logic signed [COORD_W-1:0] coord_y,
  input  logic signed [COORD_W-1:0] coord_z,
  input  logic [11:0]               point_index,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [OUT_W-1:0]   out_x,
  output logic signed [OUT_W-1:0]   out_y,
  output logic signed [OUT_W-1:0]   out_z,
  output logic [1:0]                status,
  output logic [CNT_W-1:0]          point_count
);

  localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1) << COORD_FRAC_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MEM    = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_MUL2   = 7'b0001000,
    S_DSTART = 7'b0010000,
    S_DWAIT  = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic signed [COORD_W-1:0] bmin [3];
  logic signed [COORD_W-1:0] bmax [3];
  logic signed [SUM_W-1:0]   sums [3];
  logic signed [NUM_W-1:0]   prod [3];
  logic [NUM_W-1:0]          num  [3];
  logic [NUM_W-1:0]          den_full;
  logic [EXT_W-1:0]          den_base;
  logic signed [OUT_W-1:0]   res  [3];
  logic [1:0]                res_status;
  logic [1:0]                axis;

  logic signed [COORD_W-1:0] coord_in [3];
  logic signed [COORD_W-1:0] coord_rd [3];
  logic [EXT_W-1:0]          ext [3];
  logic [EXT_W-1:0]          emax;
  logic                      anyzero;
  logic [EXT_W-1:0]          den_comb;
  logic signed [EXT_W-1:0]   ext_s [3];
  logic signed [EXT_W-1:0]   diff_s [3];

  logic   accept;
  logic   mem_wr;
  logic   mem_rd;
  point_t wr_point;
  point_t rd_point;
  logic   div_done;
  logic signed [OUT_W-1:0] div_quot;

  assign accept     = item_valid && (state == S_IDLE);
  assign item_stall = (state != S_IDLE);

  assign coord_in[0] = coord_x;
  assign coord_in[1] = coord_y;
  assign coord_in[2] = coord_z;
  assign coord_rd[0] = rd_point.x;
  assign coord_rd[1] = rd_point.y;
  assign coord_rd[2] = rd_point.z;
  assign wr_point    = '{x: coord_x, y: coord_y, z: coord_z};

  assign mem_wr = accept && (action == ACT_LOAD) && (count != CNT_W'(MAX_POINTS));
  assign mem_rd = accept && (action == ACT_READ) && (CNT_W'(point_index) < count);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext_s[a]  = EXT_W'(bmax[a]) - EXT_W'(bmin[a]);
      ext[a]    = ext_s[a][EXT_W-1] ? '0 : ext_s[a];
      diff_s[a] = EXT_W'(coord_rd[a]) - EXT_W'(bmin[a]);
    end
    emax = ext[0];
    if (ext[1] > emax) begin
      emax = ext[1];
    end
    if (ext[2] > emax) begin
      emax = ext[2];
    end
    anyzero  = (ext[0] == '0) || (ext[1] == '0) || (ext[2] == '0);
    den_comb = (anyzero && (emax < ONE_EXT)) ? ONE_EXT : emax;
  end

  mucn_store u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (wr_point),
    .rd_en   (mem_rd),
    .rd_addr (point_index[ADDR_W-1:0]),
    .rd_data (rd_point)
  );

  mucn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_DSTART),
    .num   (num[axis]),
    .den   (den_full),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
      axis         <= '0;
      for (int a = 0; a < 3; a++) begin
        bmin[a] <= '0;
        bmax[a] <= '0;
        sums[a] <= '0;
      end
    end else begin
      if (result_valid && !result_stall && (state != S_FIN)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_status <= STATUS_OK;
            axis       <= '0;
            for (int a = 0; a < 3; a++) begin
              res[a] <= '0;
            end
            state <= S_FIN;
            unique case (action_t'(action))
              ACT_LOAD: begin
                if (count == CNT_W'(MAX_POINTS)) begin
                  res_status <= STATUS_FULL;
                end else begin
                  for (int a = 0; a < 3; a++) begin
                    if (count == '0 || coord_in[a] < bmin[a]) begin
                      bmin[a] <= coord_in[a];
                    end
                    if (count == '0 || coord_in[a] > bmax[a]) begin
                      bmax[a] <= coord_in[a];
                    end
                    sums[a] <= sums[a] + SUM_W'(coord_in[a]);
                  end
                  count <= count + CNT_W'(1);
                end
              end
              ACT_READ: begin
                if (mem_rd) begin
                  state <= S_MEM;
                end else begin
                  res_status <= STATUS_BAD_INDEX;
                end
              end
              ACT_MEAN: begin
                if (count == '0) begin
                  res_status <= STATUS_BAD_INDEX;
                end else begin
                  state <= S_MUL;
                end
              end
              ACT_CLEAR: begin
                count <= '0;
                for (int a = 0; a < 3; a++) begin
                  bmin[a] <= '0;
                  bmax[a] <= '0;
                  sums[a] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_MEM: begin
          for (int a = 0; a < 3; a++) begin
            num[a] <= diff_s[a][EXT_W-1] ? '0 : NUM_W'(diff_s[a]);
          end
          den_full <= NUM_W'(den_comb);
          state    <= S_DSTART;
        end
        S_MUL: begin
          for (int a = 0; a < 3; a++) begin
            prod[a] <= $signed({1'b0, count}) * bmin[a];
          end
          den_base <= den_comb;
          state    <= S_MUL2;
        end
        S_MUL2: begin
          for (int a = 0; a < 3; a++) begin
            num[a] <= NUM_W'(NUM_W'(sums[a]) - prod[a]);
          end
          den_full <= NUM_W'(count) * NUM_W'(den_base);
          state    <= S_DSTART;
        end
        S_DSTART: begin
          state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            res[axis] <= div_quot;
            if (axis == 2'd2) begin
              state <= S_FIN;
            end else begin
              axis  <= axis + 2'd1;
              state <= S_DSTART;
            end
          end
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            out_x        <= res[0];
            out_y        <= res[1];
            out_z        <= res[2];
            status       <= res_status;
            point_count  <= count;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* bench/tb_mesh_unit_cube_normalizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the mesh unit-cube normalizer.
// A table of directed words covers the extreme coordinates, bad indexes,
// an empty mean and clears. Random loads, reads, means and clears follow.
// Every result word is checked against a predictor that keeps its own copy
// of the point store, bounding box and running sums.
// ----------------------------------------------------------------------------
module tb_mesh_unit_cube_normalizer;
  import mucn_pkg::*;

  typedef struct packed {
    logic [1:0]  act;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [11:0] idx;
  } word_t;

  typedef struct packed {
    logic        known;
    logic [17:0] ox;
    logic [17:0] oy;
    logic [17:0] oz;
    logic [1:0]  st;
    logic [12:0] cnt;
  } norm_t;

  localparam int EXP_DEPTH = 16;
  localparam int ROW_DEPTH = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] action = ACT_LOAD;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [11:0] point_index = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [17:0] out_x, out_y, out_z;
  logic [1:0] status;
  logic [12:0] point_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;
  int errors = 0;
  norm_t exp_words[EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;

  word_t table_w[ROW_DEPTH];
  norm_t table_e[ROW_DEPTH];
  int n_rows = 0;

  logic signed [31:0] pts_x[MAX_POINTS];
  logic signed [31:0] pts_y[MAX_POINTS];
  logic signed [31:0] pts_z[MAX_POINTS];
  int unsigned n_pts;
  logic signed [31:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  logic [63:0] acc_x, acc_y, acc_z;

  mesh_unit_cube_normalizer u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #400ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [17:0] map_unit(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    longint v;
    if (den == 0) return 18'(-65536);
    if (num > den) num = den;
    q = num / den;
    r = num % den;
    for (int i = 0; i < 18; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    v = longint'((q + 1) >> 1) - 65536;
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return 18'(v);
  endfunction

  function automatic logic [63:0] span(logic signed [31:0] a, logic signed [31:0] b);
    longint e;
    e = longint'(b) - longint'(a);
    return e < 0 ? 64'd0 : 64'(e);
  endfunction

  function automatic logic [63:0] box_den();
    logic [63:0] ex, ey, ez, emax;
    ex = span(lo_x, hi_x);
    ey = span(lo_y, hi_y);
    ez = span(lo_z, hi_z);
    emax = ex;
    if (ey > emax) emax = ey;
    if (ez > emax) emax = ez;
    if ((ex == 0 || ey == 0 || ez == 0) && emax < 64'd65536) return 64'd65536;
    return emax;
  endfunction

  function automatic norm_t normalize(word_t w);
    norm_t n;
    logic [63:0] den, m, c;
    n = '0;
    n.known = 1'b1;
    case (action_t'(w.act))
      ACT_LOAD: begin
        if (n_pts >= MAX_POINTS) begin
          n.st = STATUS_FULL;
        end else begin
          pts_x[n_pts] = w.cx;
          pts_y[n_pts] = w.cy;
          pts_z[n_pts] = w.cz;
          if (n_pts == 0) begin
            lo_x = w.cx; hi_x = w.cx;
            lo_y = w.cy; hi_y = w.cy;
            lo_z = w.cz; hi_z = w.cz;
          end else begin
            if ($signed(w.cx) < lo_x) lo_x = w.cx;
            if ($signed(w.cx) > hi_x) hi_x = w.cx;
            if ($signed(w.cy) < lo_y) lo_y = w.cy;
            if ($signed(w.cy) > hi_y) hi_y = w.cy;
            if ($signed(w.cz) < lo_z) lo_z = w.cz;
            if ($signed(w.cz) > hi_z) hi_z = w.cz;
          end
          acc_x += 64'($signed(w.cx));
          acc_y += 64'($signed(w.cy));
          acc_z += 64'($signed(w.cz));
          n_pts++;
        end
      end
      ACT_READ: begin
        if (w.idx >= n_pts) begin
          n.st = STATUS_BAD_INDEX;
        end else begin
          den = box_den();
          n.ox = map_unit(span(lo_x, pts_x[w.idx]), den);
          n.oy = map_unit(span(lo_y, pts_y[w.idx]), den);
          n.oz = map_unit(span(lo_z, pts_z[w.idx]), den);
        end
      end
      ACT_MEAN: begin
        if (n_pts == 0) begin
          n.st = STATUS_BAD_INDEX;
        end else begin
          c = 64'(n_pts);
          m = c * box_den();
          n.ox = map_unit(acc_x - c * 64'(lo_x), m);
          n.oy = map_unit(acc_y - c * 64'(lo_y), m);
          n.oz = map_unit(acc_z - c * 64'(lo_z), m);
        end
      end
      default: begin
        n_pts = 0;
        lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; lo_z = 0; hi_z = 0;
        acc_x = 0; acc_y = 0; acc_z = 0;
      end
    endcase
    n.cnt = 13'(n_pts);
    return n;
  endfunction

  // A typed-in expected word from the table is checked against the predictor.
  task automatic send_word(word_t w, norm_t typed_in);
    norm_t n;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    action <= w.act;
    coord_x <= w.cx;
    coord_y <= w.cy;
    coord_z <= w.cz;
    point_index <= w.idx;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    n = normalize(w);
    if (typed_in.known) begin
      if (typed_in != n) begin
        $error("predictor disagrees with table: expected %h got %h", typed_in, n);
        errors++;
      end
    end
    exp_words[exp_wr % EXP_DEPTH] = n;
    exp_wr++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    norm_t e;
    if (!rst && result_valid && !result_stall) begin
      if (exp_wr == exp_rd) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = exp_words[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (out_x !== e.ox) begin
          $error("out_x expected %0d got %0d", $signed(e.ox), out_x); errors++;
        end
        if (out_y !== e.oy) begin
          $error("out_y expected %0d got %0d", $signed(e.oy), out_y); errors++;
        end
        if (out_z !== e.oz) begin
          $error("out_z expected %0d got %0d", $signed(e.oz), out_z); errors++;
        end
        if (status !== e.st) begin
          $error("status expected %0d got %0d", e.st, status); errors++;
        end
        if (point_count !== e.cnt) begin
          $error("point_count expected %0d got %0d", e.cnt, point_count); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) << 12;
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(20)) - 10);
    endcase
  endfunction

  task automatic random_word(output word_t w);
    int r;
    int mode;
    r = $urandom_range(99);
    mode = $urandom_range(3);
    w.cx = rand_coord(mode);
    w.cy = rand_coord(mode);
    w.cz = rand_coord($urandom_range(3));
    w.idx = (n_pts > 0 && $urandom_range(9) > 0) ? 12'($urandom_range(n_pts - 1))
                                                  : 12'($urandom);
    if (r < 45) w.act = ACT_LOAD;
    else if (r < 85) w.act = ACT_READ;
    else if (r < 97) w.act = ACT_MEAN;
    else w.act = ACT_CLEAR;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic row(logic [1:0] a, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                     logic [11:0] i, logic k, logic [17:0] ex, logic [17:0] ey,
                     logic [17:0] ez, logic [1:0] st, logic [12:0] cnt);
    table_w[n_rows] = {a, x, y, z, i};
    table_e[n_rows] = {k, ex, ey, ez, st, cnt};
    n_rows++;
  endtask

  initial begin
    word_t w;
    n_pts = 0;
    lo_x = 0; hi_x = 0; lo_y = 0; hi_y = 0; lo_z = 0; hi_z = 0;
    acc_x = 0; acc_y = 0; acc_z = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    row(ACT_MEAN, 0, 0, 0, 0, 1, 0, 0, 0, STATUS_BAD_INDEX, 0);
    row(ACT_READ, 0, 0, 0, 0, 1, 0, 0, 0, STATUS_BAD_INDEX, 0);
    row(ACT_LOAD, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 1, 0, 0, 0, STATUS_OK, 1);
    row(ACT_READ, 0, 0, 0, 0, 1, 18'(-65536), 18'(-65536), 18'(-65536), STATUS_OK, 1);
    row(ACT_MEAN, 0, 0, 0, 0, 1, 18'(-65536), 18'(-65536), 18'(-65536), STATUS_OK, 1);
    row(ACT_READ, 0, 0, 0, 12'hFFF, 1, 0, 0, 0, STATUS_BAD_INDEX, 1);
    row(ACT_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 0, 1, 0, 0, 0, STATUS_OK, 2);
    row(ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_8000, 0, 1, 0, 0, 0, STATUS_OK, 3);
    row(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row(ACT_READ, 0, 0, 0, 1, 1, 18'(-65536), 18'(-65536), 18'(-65536), STATUS_OK, 3);
    row(ACT_READ, 0, 0, 0, 2, 1, 18'd65536, 18'd65536, 18'(-65535), STATUS_OK, 3);
    row(ACT_MEAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row(ACT_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0, STATUS_OK, 0);
    row(ACT_READ, 0, 0, 0, 0, 1, 0, 0, 0, STATUS_BAD_INDEX, 0);
    row(ACT_LOAD, 32'hFFFF_0000, 32'h0000_0000, 32'h0000_0005, 0, 0, 0, 0, 0, 0, 0);
    row(ACT_LOAD, 32'h0002_0000, 32'h0000_0003, 32'h0000_0005, 0, 0, 0, 0, 0, 0, 0);
    row(ACT_READ, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
    row(ACT_MEAN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row(ACT_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0, STATUS_OK, 0);

    for (int i = 0; i < n_rows; i++) send_word(table_w[i], table_e[i]);

    // A long hold-off on the result side while words keep coming.
    hold_off = 400;
    for (int i = 0; i < 20; i++) begin
      random_word(w);
      send_word(w, '0);
    end
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 56; end
        3: begin send_idle_pct = 13; recv_stall_pct = 13; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 250; i++) begin
        random_word(w);
        send_word(w, '0);
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
